// File: design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_CLK_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Property checked on every clock edge, reset included.
`define ASSERT_CLK(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// File: design/srs_pkg.sv
package srs_pkg;

   // Tracker states
   localparam logic [2:0] ST_BEHIND = 3'd0;
   localparam logic [2:0] ST_AHEAD  = 3'd1;
   localparam logic [2:0] ST_LOCKED = 3'd2;
   localparam logic [2:0] ST_SLEW   = 3'd3;
   localparam logic [2:0] ST_HOLD   = 3'd4;

   // Pass kinds
   localparam logic OP_COMPARE = 1'b0;
   localparam logic OP_SM_ONLY = 1'b1;

   // Waveform driver modes
   localparam logic [2:0] CMD_NONE  = 3'd0;
   localparam logic [2:0] CMD_MODE1 = 3'd1;
   localparam logic [2:0] CMD_MODE2 = 3'd2;
   localparam logic [2:0] CMD_MODE3 = 3'd3;
   localparam logic [2:0] CMD_MODE4 = 3'd4;

   // Waveform codes (6-bit)
   localparam logic [5:0] CODE_NONE = 6'd0;
   localparam logic [5:0] CODE_HOLD = 6'd4;
   localparam logic [5:0] CODE_ODD  = 6'd8;
   localparam logic [5:0] CODE_WIDE = 6'h10;
   localparam logic [5:0] CODE_EVEN = 6'h30;

   // Position thresholds
   localparam logic [7:0] POS_LIMIT  = 8'd5;
   localparam logic [8:0] POS_MARGIN = 9'd2;

   typedef struct packed {
      logic       opcode;
      logic [7:0] old_position;
      logic [7:0] new_position;
      logic [7:0] step_value;
   } srs_req_type;

   typedef struct packed {
      logic [2:0] tracker_state;
      logic [2:0] wave_command;
      logic [5:0] wave_code;
      logic       capture_valid;
      logic [7:0] capture_value;
   } srs_rsp_type;

endpackage

// File: design/srs_if.sv
// Request channel: one tracker pass per transaction.
interface srs_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] old_position;
   logic [7:0] new_position;
   logic [7:0] step_value;

   modport source (output valid, opcode, old_position, new_position, step_value,
                   input ready);
   modport sink   (input valid, opcode, old_position, new_position, step_value,
                   output ready);
endinterface

// Response channel: one result per pass.
interface srs_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] tracker_state;
   logic [2:0] wave_command;
   logic [5:0] wave_code;
   logic       capture_valid;
   logic [7:0] capture_value;

   modport source (output valid, tracker_state, wave_command, wave_code,
                   capture_valid, capture_value,
                   input ready);
   modport sink   (input valid, tracker_state, wave_command, wave_code,
                   capture_valid, capture_value,
                   output ready);
endinterface

// File: design/srs_step.sv
// Next-state and waveform decode for one tracker pass.
module srs_step
   import srs_pkg::*;
(
   input  logic [2:0]  state_cur,
   input  srs_req_type pass_in,
   output logic [2:0]  state_nxt,
   output srs_rsp_type result
);

   logic       pos_gt;
   logic       pos_eq;
   logic       odd;
   logic       npos_zero;
   logic       npos_far;
   logic       opos_near;
   logic       margin_ok;
   logic       flag;
   logic [2:0] cur;
   logic [2:0] nxt;

   // Position compares
   assign pos_gt    = pass_in.old_position > pass_in.new_position;
   assign pos_eq    = pass_in.old_position == pass_in.new_position;
   assign odd       = pass_in.step_value[0];
   assign npos_zero = pass_in.new_position == 8'd0;
   assign npos_far  = pass_in.new_position >= POS_LIMIT;
   assign opos_near = pass_in.old_position < POS_LIMIT;
   // old - 2 >= new, with old below two counting as negative
   assign margin_ok = {1'b0, pass_in.old_position} >= ({1'b0, pass_in.new_position} + POS_MARGIN);

   // Compare stage (compare passes only), then transition rules
   always_comb begin
      cur  = state_cur;
      flag = 1'b0;
      if (pass_in.opcode == OP_COMPARE) begin
         if (pos_gt) begin
            cur = ST_BEHIND;
         end else if (pos_eq) begin
            cur  = ST_LOCKED;
            flag = 1'b1;
         end else begin
            cur = ST_AHEAD;
         end
      end
      nxt = cur;
      unique case (cur)
         ST_BEHIND: begin
            if (pos_gt || pos_eq) begin
               if (pos_eq && !odd) begin
                  nxt  = ST_LOCKED;
                  flag = 1'b1;
               end
            end else if (!odd) begin
               nxt = ST_SLEW;
            end
         end
         ST_AHEAD: begin
            if (pos_gt) begin
               if (!odd || npos_zero) nxt = ST_SLEW;
            end else if (pos_eq) begin
               if (!odd || npos_zero) begin
                  if (npos_far) begin
                     nxt = ST_HOLD;
                  end else begin
                     nxt  = ST_LOCKED;
                     flag = 1'b1;
                  end
               end
            end
         end
         ST_LOCKED: begin
            if (pos_gt) nxt = ST_BEHIND;
            else if (!pos_eq) nxt = ST_AHEAD;
         end
         ST_SLEW: begin
            if (pos_gt) begin
               nxt = ST_BEHIND;
            end else if (!pos_eq) begin
               nxt = ST_AHEAD;
            end else begin
               nxt  = ST_LOCKED;
               flag = 1'b1;
            end
         end
         ST_HOLD: begin
            if (!odd) begin
               // near-zero old position overrides the slew rule
               if (opos_near) begin
                  nxt  = ST_LOCKED;
                  flag = 1'b1;
               end else if (margin_ok) begin
                  nxt = ST_SLEW;
               end
            end
         end
         default: nxt = cur;
      endcase
   end

   assign state_nxt = nxt;

   // Waveform command, code and capture from the new state
   always_comb begin
      result               = '0;
      result.tracker_state = nxt;
      unique case (nxt)
         ST_BEHIND: begin
            result.wave_command = CMD_MODE2;
            result.wave_code    = CODE_WIDE;
         end
         ST_AHEAD, ST_HOLD: begin
            if (npos_far) begin
               result.wave_command = CMD_MODE3;
               result.wave_code    = CODE_WIDE;
            end else begin
               result.wave_command = CMD_MODE1;
               result.wave_code    = odd ? CODE_ODD : CODE_EVEN;
            end
         end
         ST_LOCKED: begin
            if (flag && npos_zero) begin
               result.capture_valid = 1'b1;
               result.capture_value = pass_in.step_value;
            end else begin
               result.wave_command = CMD_MODE4;
            end
            result.wave_code = CODE_HOLD;
         end
         ST_SLEW: begin
            result.wave_command = CMD_NONE;
            result.wave_code    = CODE_EVEN;
         end
         default: begin
            result.wave_command = CMD_NONE;
            result.wave_code    = CODE_NONE;
         end
      endcase
   end

endmodule

// File: design/stepper_rotor_sync_state_machine.sv
// A pass goes through the input register, then the response register.
// Throughput: one pass per cycle while the response side is not stalled; the tracker
// state register closes its loop between the input register and the response register,
// loading on the same edge as the response register.
// Reset (synchronous, active high) clears the tracker state to 0 and empties
// both the input and response registers.
module stepper_rotor_sync_state_machine
   import srs_pkg::*;
(
   input logic       clock,
   input logic       reset,
   srs_req_if.sink   req,
   srs_rsp_if.source rsp
);

   logic        in_valid_ff;
   logic        in_valid_in;
   srs_req_type in_data_ff;
   logic        out_valid_ff;
   logic        out_valid_in;
   srs_rsp_type out_data_ff;
   logic [2:0]  state_ff;
   logic [2:0]  state_in;
   srs_rsp_type result;
   logic        advance;
   logic        req_take;

   // Handshake: input stage moves when the response register is free or draining
   assign advance  = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign req_take = req.valid && req.ready;

   srs_step u_step (
      .state_cur (state_ff),
      .pass_in   (in_data_ff),
      .state_nxt (state_in),
      .result    (result)
   );

   // Input register
   assign in_valid_in = req_take || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff.opcode       <= req.opcode;
         in_data_ff.old_position <= req.old_position;
         in_data_ff.new_position <= req.new_position;
         in_data_ff.step_value   <= req.step_value;
      end
   end

   // Tracker state and response register
   assign out_valid_in = advance || (out_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         state_ff     <= ST_BEHIND;
      end else begin
         out_valid_ff <= out_valid_in;
         if (advance) state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) out_data_ff <= result;
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.tracker_state = out_data_ff.tracker_state;
   assign rsp.wave_command  = out_data_ff.wave_command;
   assign rsp.wave_code     = out_data_ff.wave_code;
   assign rsp.capture_valid = out_data_ff.capture_valid;
   assign rsp.capture_value = out_data_ff.capture_value;

endmodule

// File: design/srs_checker.sv
`include "assert_macros.svh"

// Port-level checks on the tracker's response stream.
module srs_checker
   import srs_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_tracker_state,
   input logic [2:0] rsp_wave_command,
   input logic [5:0] rsp_wave_code,
   input logic       rsp_capture_valid,
   input logic [7:0] rsp_capture_value
);

   // A stalled response keeps its state
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tracker_state))
   // Capture only in the locked state with the hold code and no waveform call
   `ASSERT_CLK_RST(a_capture_locked, clock, reset, rsp_valid && rsp_capture_valid |-> rsp_tracker_state == ST_LOCKED && rsp_wave_code == CODE_HOLD && rsp_wave_command == CMD_NONE)
   // Without a capture the capture byte reads zero
   `ASSERT_CLK_RST(a_capture_zero, clock, reset, rsp_valid && !rsp_capture_valid |-> rsp_capture_value == 8'd0)
   // Slew state drives no waveform call and the even code
   `ASSERT_CLK_RST(a_slew_code, clock, reset, rsp_valid && rsp_tracker_state == ST_SLEW |-> rsp_wave_command == CMD_NONE && rsp_wave_code == CODE_EVEN)
   // Nothing is offered right after reset
   `ASSERT_CLK(a_reset_empty, clock, $past(reset) |-> !rsp_valid)

endmodule

bind stepper_rotor_sync_state_machine srs_checker u_srs_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_tracker_state (rsp.tracker_state),
   .rsp_wave_command  (rsp.wave_command),
   .rsp_wave_code     (rsp.wave_code),
   .rsp_capture_valid (rsp.capture_valid),
   .rsp_capture_value (rsp.capture_value)
);
